@@ hw/rtl/square_matrix_multiply_unit_macros.svh @@
// assertion macros for the square matrix multiply unit
`ifndef SQUARE_MATRIX_MULTIPLY_UNIT_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SMM_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smm assertion failed");
`define SMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smm assertion failed");
`else
`define SMM_ASSERT_IMPLIES(lbl, ante, cons)
`define SMM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/smm_pkg.sv @@
// shared types and constants for the square matrix multiply unit
package smm_pkg;

  localparam int MAX_DIM_DEF       = 32;
  localparam int ELEMENT_WIDTH_DEF = 16;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 5;
  localparam int VALUE_W   = 16;
  localparam int SIZE_W    = 6;
  localparam int PRODUCT_W = 37;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [IDX_W-1:0]          row_index;
    logic [IDX_W-1:0]          col_index;
    logic signed [VALUE_W-1:0] element_value;
  } in_word_t;

  typedef struct packed {
    logic signed [PRODUCT_W-1:0] product_value;
    logic                        index_error;
  } out_word_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic fail;
    logic issue;
    logic out_load;
  } smm_cmd_t;

  typedef struct packed {
    logic in_ok;
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } smm_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } smm_state_t;

endpackage

@@ hw/rtl/smm_ctrl.sv @@
// controller state machine for the square matrix multiply unit
module smm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [smm_pkg::CMD_W-1:0] in_command,
  output logic                in_stall,
  input  smm_pkg::smm_status_t sts,
  output smm_pkg::smm_cmd_t   cmd
);

  smm_pkg::smm_state_t state_r, state_nxt;

  logic take;
  assign take = in_valid && (state_r == smm_pkg::ST_IDLE);
  assign in_stall = (state_r != smm_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smm_pkg::ST_IDLE: begin
        if (take && in_command == smm_pkg::CMD_COMPUTE) begin
          state_nxt = sts.in_ok ? smm_pkg::ST_RUN : smm_pkg::ST_FINISH;
        end
      end
      smm_pkg::ST_RUN: begin
        if (sts.last_issue) begin
          state_nxt = smm_pkg::ST_DRAIN;
        end
      end
      smm_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = smm_pkg::ST_FINISH;
        end
      end
      smm_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = smm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = smm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      smm_pkg::ST_IDLE: begin
        cmd.load_a = take && sts.in_ok && (in_command == smm_pkg::CMD_WRITE_A);
        cmd.load_b = take && sts.in_ok && (in_command == smm_pkg::CMD_WRITE_B);
        cmd.start  = take && sts.in_ok && (in_command == smm_pkg::CMD_COMPUTE);
        cmd.fail   = take && !sts.in_ok && (in_command == smm_pkg::CMD_COMPUTE);
      end
      smm_pkg::ST_RUN: begin
        cmd.issue = 1'b1;
      end
      smm_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      smm_pkg::ST_FINISH: begin
        cmd.out_load = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ hw/rtl/smm_datapath.sv @@
// stores, multiply-accumulate pipeline and output register
module smm_datapath #(
  parameter int MAX_DIM       = smm_pkg::MAX_DIM_DEF,
  parameter int ELEMENT_WIDTH = smm_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_write_en,
  input  logic [smm_pkg::SIZE_W-1:0] cfg_write_data,
  input  smm_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output smm_pkg::out_word_t        out_word,
  input  smm_pkg::smm_cmd_t         cmd,
  output smm_pkg::smm_status_t      sts
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = (MAX_DIM > 1) ? $clog2(Depth) : 1;
  localparam int EW    = ELEMENT_WIDTH;
  localparam int SW    = smm_pkg::SIZE_W;
  localparam int PW    = smm_pkg::PRODUCT_W;
  localparam logic [SW:0] MaxDimW = (SW + 1)'(MAX_DIM);

  logic [EW-1:0] a_mem [Depth];
  logic [EW-1:0] b_mem [Depth];

  logic [SW-1:0]            size_r;
  logic [SW-1:0]            n_use;
  logic [smm_pkg::IDX_W-1:0] row_r, col_r;
  logic [SW-1:0]            k_r;
  logic                     err_r;
  logic signed [EW-1:0]     a_rd_r, b_rd_r;
  logic signed [2*EW-1:0]   prod_r;
  logic                     rd_vld_r, mul_vld_r;
  logic [PW-1:0]            acc_r;
  logic                     out_valid_r;
  smm_pkg::out_word_t       out_word_r;

  logic [31:0]      raw;
  logic [EW-1:0]    elem;
  logic [AddrW-1:0] waddr, a_raddr, b_raddr;
  logic [63:0]      prod_ext;

  // size in use saturates at the store dimension
  assign n_use = ({1'b0, size_r} > MaxDimW) ? MaxDimW[SW-1:0] : size_r;

  assign sts.in_ok = ({1'b0, in_word.row_index} < n_use) &&
                     ({1'b0, in_word.col_index} < n_use);
  assign sts.last_issue = (k_r == n_use - 1'b1);
  assign sts.pipe_busy  = rd_vld_r || mul_vld_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  // element is the low bits of the field, taken as two's complement
  assign raw  = {16'b0, in_word.element_value};
  assign elem = raw[EW-1:0];

  assign waddr   = AddrW'(in_word.row_index * MAX_DIM + in_word.col_index);
  assign a_raddr = AddrW'(row_r * MAX_DIM + k_r);
  assign b_raddr = AddrW'(k_r * MAX_DIM + col_r);

  assign prod_ext = 64'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_mem[waddr] <= elem;
    end
    if (cmd.load_b) begin
      b_mem[waddr] <= elem;
    end
    a_rd_r <= a_mem[a_raddr];
    b_rd_r <= b_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= smm_pkg::SIZE_RESET;
      k_r         <= '0;
      rd_vld_r    <= 1'b0;
      mul_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        size_r <= cfg_write_data;
      end
      if (cmd.start) begin
        k_r <= '0;
      end else if (cmd.issue) begin
        k_r <= k_r + 1'b1;
      end
      rd_vld_r  <= cmd.issue;
      mul_vld_r <= rd_vld_r;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r <= in_word.row_index;
      col_r <= in_word.col_index;
    end
    if (cmd.start || cmd.fail) begin
      err_r <= cmd.fail;
      acc_r <= '0;
    end else if (mul_vld_r) begin
      acc_r <= acc_r + prod_ext[PW-1:0];
    end
    prod_r <= a_rd_r * b_rd_r;
    if (cmd.out_load) begin
      out_word_r.product_value <= acc_r;
      out_word_r.index_error   <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ hw/rtl/square_matrix_multiply_unit.sv @@
// top level of the square matrix multiply unit
// usage:
//   in_valid/in_stall/in_word carries load and compute words. a write A or
//   write B word in range stores one element, is taken when idle and gives no
//   result. a compute word returns one out_word on out_valid/out_stall with
//   the dot product of row row_index of A and column col_index of B.
//   cfg_write_en/cfg_write_data sets the matrix size; the user must write it
//   only while idle, and the block itself does not enforce this.
//   a compute word holds the input side until its result is loaded into the
//   output register. n element pairs, n the size in use, are read one pair
//   per cycle from the stores and fed through a read, multiply and accumulate
//   pipeline, so the single read port of each store sets the rate. an index
//   out of range answers with zero and index_error set.
// reset:
//   rst_n clears the controller, the output valid and sets the size to 32.
//   store contents are undefined until written.
// stall:
//   a finished result waits in the output register; load words are still
//   taken while it waits, and the next compute runs until its result needs
//   the register.
`include "square_matrix_multiply_unit_macros.svh"

module square_matrix_multiply_unit #(
  parameter int MAX_DIM       = smm_pkg::MAX_DIM_DEF,
  parameter int ELEMENT_WIDTH = smm_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_write_en,
  input  logic [smm_pkg::SIZE_W-1:0] cfg_write_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  smm_pkg::in_word_t          in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output smm_pkg::out_word_t         out_word
);

  smm_pkg::smm_cmd_t    cmd;
  smm_pkg::smm_status_t sts;

  smm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_word.command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  smm_datapath #(
    .MAX_DIM       (MAX_DIM),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .cmd            (cmd),
    .sts            (sts)
  );

  // a taken compute word holds off the next word
  `SMM_ASSERT_NEXT(a_compute_holds, cmd.start || cmd.fail, in_stall)
  // an error result carries a zero product
  `SMM_ASSERT_IMPLIES(a_error_zero, out_valid && out_word.index_error, out_word.product_value == '0)
  // the result is captured only once the pipeline is empty
  `SMM_ASSERT_IMPLIES(a_load_after_drain, cmd.out_load, !sts.pipe_busy && !cmd.issue)

endmodule

@@ bench/square_matrix_multiply_unit_test.sv @@
// self-checking testbench for the square matrix multiply unit
`timescale 1ns / 1ps

module square_matrix_multiply_unit_test;

  localparam int DIM    = smm_pkg::MAX_DIM_DEF;
  localparam int SETTLE = 48;
  localparam logic [smm_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_write_en = 1'b0;
  logic [smm_pkg::SIZE_W-1:0] cfg_write_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  smm_pkg::in_word_t          in_word = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  smm_pkg::out_word_t         out_word;

  square_matrix_multiply_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word)
  );

  always #1 clk = ~clk;

  // shadow copy of the stores and the size register
  logic signed [smm_pkg::VALUE_W-1:0] shadow_a [DIM*DIM];
  logic signed [smm_pkg::VALUE_W-1:0] shadow_b [DIM*DIM];
  logic [smm_pkg::SIZE_W-1:0]         shadow_size = smm_pkg::SIZE_RESET;

  smm_pkg::out_word_t pending_products [$];
  smm_pkg::in_word_t  send_words [$];

  // entries written so far, so that no compute reads an unwritten one
  bit a_filled [DIM*DIM];
  bit b_filled [DIM*DIM];
  int gen_n = DIM;
  int queued_live = 0;

  int idle_mode = 1;
  int failures = 0;
  int words_taken = 0;
  int products_ok = 0;
  int products_flagged = 0;

  function automatic void shadow_step(smm_pkg::in_word_t w);
    int                 n;
    bit                 ok;
    longint             acc;
    smm_pkg::out_word_t r;
    n   = (int'(shadow_size) > DIM) ? DIM : int'(shadow_size);
    ok  = (int'(w.row_index) < n) && (int'(w.col_index) < n);
    acc = 0;
    case (w.command)
      smm_pkg::CMD_WRITE_A: begin
        if (ok) shadow_a[int'(w.row_index)*DIM + int'(w.col_index)] = w.element_value;
      end
      smm_pkg::CMD_WRITE_B: begin
        if (ok) shadow_b[int'(w.row_index)*DIM + int'(w.col_index)] = w.element_value;
      end
      smm_pkg::CMD_COMPUTE: begin
        if (ok) begin
          for (int k = 0; k < n; k++) begin
            acc += longint'(shadow_a[int'(w.row_index)*DIM + k]) *
                   longint'(shadow_b[k*DIM + int'(w.col_index)]);
          end
        end
        r.product_value = acc[smm_pkg::PRODUCT_W-1:0];
        r.index_error   = !ok;
        pending_products.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [smm_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return (smm_pkg::VALUE_W)'($urandom);
    endcase
  endfunction

  function automatic void queue_word(logic [smm_pkg::CMD_W-1:0] cmd, int r, int c,
                                     logic signed [smm_pkg::VALUE_W-1:0] v);
    smm_pkg::in_word_t w;
    bit                ok;
    w.command       = cmd;
    w.row_index     = (smm_pkg::IDX_W)'(r);
    w.col_index     = (smm_pkg::IDX_W)'(c);
    w.element_value = v;
    send_words.push_back(w);
    ok = (r < gen_n) && (c < gen_n);
    if (cmd == smm_pkg::CMD_COMPUTE) queued_live++;
    if (cmd == smm_pkg::CMD_WRITE_A && ok) begin
      a_filled[r*DIM + c] = 1'b1;
      queued_live++;
    end
    if (cmd == smm_pkg::CMD_WRITE_B && ok) begin
      b_filled[r*DIM + c] = 1'b1;
      queued_live++;
    end
  endfunction

  // compute word, preceded by writes for any operand not yet loaded
  function automatic void queue_compute(int r, int c);
    if (r < gen_n && c < gen_n) begin
      for (int k = 0; k < gen_n; k++) begin
        if (!a_filled[r*DIM + k]) queue_word(smm_pkg::CMD_WRITE_A, r, k, pick_value());
        if (!b_filled[k*DIM + c]) queue_word(smm_pkg::CMD_WRITE_B, k, c, pick_value());
      end
    end
    queue_word(smm_pkg::CMD_COMPUTE, r, c, pick_value());
  endfunction

  function automatic int any_index();
    if (gen_n > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, gen_n - 1);
    return $urandom_range(0, DIM - 1);
  endfunction

  // mostly a few low rows and columns, so large sizes reuse loaded operands
  function automatic int near_index();
    if (gen_n == 0) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, gen_n - 1);
    return $urandom_range(0, (gen_n > 4) ? 3 : gen_n - 1);
  endfunction

  // sender: bursts and gaps, with an occasional pause until results drain
  int burst_left = 0;
  int gap_left = 0;
  bit hold_for_drain = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        shadow_step(in_word);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (hold_for_drain && pending_products.size() != 0) begin
          in_valid <= 1'b0;
        end else if (send_words.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          hold_for_drain = 0;
          in_word  <= send_words.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            if (idle_mode == 0) begin
              burst_left = 1000;
              gap_left   = 0;
            end else begin
              burst_left     = $urandom_range(1, 24);
              gap_left       = (idle_mode == 2) ? $urandom_range(0, 12) : $urandom_range(0, 3);
              if ($urandom_range(0, 19) == 0) gap_left = $urandom_range(20, 60);
              hold_for_drain = ($urandom_range(0, 11) == 0);
            end
          end
        end
      end
    end
  end

  // receiver stall pattern
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n || idle_mode == 0) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      case ($urandom_range(0, 15))
        0, 1, 2: stall_left = $urandom_range(1, 4);
        3: stall_left = $urandom_range(5, 20);
        4: if (idle_mode == 2) stall_left = $urandom_range(30, 70);
        default: ;
      endcase
    end
  end

  smm_pkg::out_word_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_products.size() == 0) begin
        $error("result word with none expected: product_value=%0d index_error=%0b",
               out_word.product_value, out_word.index_error);
        failures++;
      end else begin
        want = pending_products.pop_front();
        if (out_word.product_value !== want.product_value) begin
          $error("product_value expected %0d, got %0d", want.product_value,
                 out_word.product_value);
          failures++;
        end
        if (out_word.index_error !== want.index_error) begin
          $error("index_error expected %0b, got %0b", want.index_error,
                 out_word.index_error);
          failures++;
        end
        if (want.index_error) products_flagged++;
        else products_ok++;
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (send_words.size() != 0 || in_valid || pending_products.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_size(int v);
    wait_idle();
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= (smm_pkg::SIZE_W)'(v);
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    shadow_size = (smm_pkg::SIZE_W)'(v);
    gen_n       = (v > DIM) ? DIM : v;
  endtask

  task automatic run_random(int budget);
    int start;
    int pick;
    start = queued_live;
    while (queued_live - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) queue_word(smm_pkg::CMD_WRITE_A, any_index(), any_index(), pick_value());
      else if (pick < 28) queue_word(smm_pkg::CMD_WRITE_B, any_index(), any_index(),
                                     pick_value());
      else if (pick < 32) queue_word(CMD_RESERVED, $urandom_range(0, DIM - 1),
                                     $urandom_range(0, DIM - 1), pick_value());
      else if (pick < 40) queue_compute($urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1));
      else queue_compute(near_index(), near_index());
    end
  endtask

  int phase_sizes [] = '{1, 2, 0, 32, 63, 3, 5, 7, 12, 33, 16, 24, 31, 4, 32};

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset size: unused command, then sums at the output extremes
    queue_word(CMD_RESERVED, 0, 0, pick_value());
    queue_word(CMD_RESERVED, DIM - 1, DIM - 1, pick_value());
    for (int k = 0; k < DIM; k++) begin
      queue_word(smm_pkg::CMD_WRITE_A, 0, k, -16'sd32768);
      queue_word(smm_pkg::CMD_WRITE_B, k, 0, -16'sd32768);
      queue_word(smm_pkg::CMD_WRITE_A, DIM - 1, k, -16'sd32768);
      queue_word(smm_pkg::CMD_WRITE_B, k, DIM - 1, 16'sd32767);
    end
    queue_compute(0, 0);
    queue_compute(DIM - 1, DIM - 1);
    queue_compute(0, DIM - 1);
    queue_compute(DIM - 1, 0);

    // smallest size: loads out of range are dropped, computes flagged
    set_size(1);
    queue_word(smm_pkg::CMD_WRITE_A, 0, 0, 16'sd32767);
    queue_word(smm_pkg::CMD_WRITE_B, 0, 0, 16'sd32767);
    queue_word(smm_pkg::CMD_WRITE_A, 0, 1, 16'sd5);
    queue_word(smm_pkg::CMD_WRITE_B, 1, 0, 16'sd5);
    queue_word(smm_pkg::CMD_WRITE_A, DIM - 1, DIM - 1, 16'sd9);
    queue_compute(0, 0);
    queue_compute(0, 1);
    queue_compute(1, 0);
    queue_compute(DIM - 1, DIM - 1);

    // size zero: nothing in range
    set_size(0);
    queue_word(smm_pkg::CMD_WRITE_A, 0, 0, 16'sd1);
    queue_compute(0, 0);
    queue_compute(DIM - 1, DIM - 1);

    // size above the maximum saturates
    set_size(63);
    queue_compute(DIM - 1, DIM - 1);
    queue_compute(0, 0);

    for (int p = 0; p < phase_sizes.size(); p++) begin
      set_size(phase_sizes[p]);
      idle_mode = p % 3;
      run_random(84);
    end

    wait_idle();
    $display("ran %0d words through sizes 0 to 63, including the saturated range",
             words_taken);
    $display("checked %0d dot products and %0d out-of-range answers",
             products_ok, products_flagged);
    if (failures == 0 && pending_products.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d results outstanding", pending_products.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/smm_pkg.sv
hw/rtl/smm_ctrl.sv
hw/rtl/smm_datapath.sv
hw/rtl/square_matrix_multiply_unit.sv
bench/square_matrix_multiply_unit_test.sv
